FILE: src/rsce_pkg.sv
// shared types, constants and helper functions for the reduced sha-256 carry extractor
`default_nettype none

package rsce_pkg;

   // rounds 57 to 63 of the compression function
   localparam int NUM_ROUNDS       = 7;
   // additions per round that report carries
   localparam int NUM_ADDS         = 7;
   // state words a..h
   localparam int NUM_STATE        = 8;
   // one result beat per path and round
   localparam int RESULTS_PER_ITEM = 2 * NUM_ROUNDS;
   // fixed widths of the stream fields
   localparam int WORDS_FIELD_W    = 56;
   localparam int CARRY_FIELD_W    = 56;
   localparam int CSR_DATA_W       = 64;

   // register indexes
   localparam logic CSR_FIRST_START  = 1'b0;
   localparam logic CSR_SECOND_START = 1'b1;

   // round constants k[57..63]
   localparam logic [31:0] TAIL_K [NUM_ROUNDS] = '{
      32'h78a5636f, 32'h84c87814, 32'h8cc70208, 32'h90befffa,
      32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // control travelling with a token along the chain
   typedef struct packed {
      logic valid;
      logic path;
   } token_ctrl_type;

   // standard rotation scaled to the word width, half to even, at least 1,
   // an amount equal to the width wraps to zero
   function automatic int scaled_rot(input int k, input int wbits);
      int num;
      int q;
      int rem;
      num = k * wbits;
      q   = num / 32;
      rem = num % 32;
      if ((rem > 16) || ((rem == 16) && ((q & 1) == 1))) begin
         q = q + 1;
      end
      if (q < 1) begin
         q = 1;
      end
      if (q >= wbits) begin
         q = 0;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

FILE: src/rsce_round_cell.sv
// one compression round cell of the chain, registered, with carry capture
`default_nettype none

module rsce_round_cell #(
   parameter int WORD_BITS = 8,
   parameter int ROUND     = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire rsce_pkg::token_ctrl_type              in_ctrl,
   input  wire logic [rsce_pkg::NUM_STATE*WORD_BITS-1:0] in_state,
   input  wire logic [rsce_pkg::NUM_ROUNDS*WORD_BITS-1:0] in_words,
   input  wire logic [rsce_pkg::NUM_ROUNDS*rsce_pkg::NUM_ADDS*WORD_BITS-1:0] in_carries,
   output rsce_pkg::token_ctrl_type                   out_ctrl,
   output logic [rsce_pkg::NUM_STATE*WORD_BITS-1:0]   out_state,
   output logic [rsce_pkg::NUM_ROUNDS*WORD_BITS-1:0]  out_words,
   output logic [rsce_pkg::NUM_ROUNDS*rsce_pkg::NUM_ADDS*WORD_BITS-1:0] out_carries
);

   localparam int W   = WORD_BITS;
   localparam int SW  = rsce_pkg::NUM_STATE * W;
   localparam int WW  = rsce_pkg::NUM_ROUNDS * W;
   localparam int RW  = rsce_pkg::NUM_ADDS * W;
   localparam int CW  = rsce_pkg::NUM_ROUNDS * RW;

   localparam int S0_R0 = rsce_pkg::scaled_rot(2, W);
   localparam int S0_R1 = rsce_pkg::scaled_rot(13, W);
   localparam int S0_R2 = rsce_pkg::scaled_rot(22, W);
   localparam int S1_R0 = rsce_pkg::scaled_rot(6, W);
   localparam int S1_R1 = rsce_pkg::scaled_rot(11, W);
   localparam int S1_R2 = rsce_pkg::scaled_rot(25, W);

   localparam logic [31:0]  K_FULL = rsce_pkg::TAIL_K[ROUND];
   localparam logic [W-1:0] K_WORD = K_FULL[W-1:0];

   function automatic logic [W-1:0] rotr(input logic [W-1:0] x, input int amt);
      return (x >> amt) | (x << (W - amt));
   endfunction

   // carry out of each bit position of x + y
   function automatic logic [W-1:0] add_carries(input logic [W-1:0] x, input logic [W-1:0] y);
      logic [W:0] sum;
      logic [W:0] mix;
      sum = {1'b0, x} + {1'b0, y};
      mix = sum ^ {1'b0, x} ^ {1'b0, y};
      return mix[W:1];
   endfunction

   rsce_pkg::token_ctrl_type ctrl_ff;
   logic [SW-1:0] state_ff, state_in;
   logic [WW-1:0] words_ff;
   logic [CW-1:0] carries_ff, carries_in;

   logic [W-1:0] a, b, c, d, e, f, g, h, w;
   logic [W-1:0] sg0, sg1, ch, mj, t0, t1, t2, big_t1, big_t2, new_a, new_e;
   logic [RW-1:0] round_carries;

   always_comb begin
      a = in_state[0*W +: W];
      b = in_state[1*W +: W];
      c = in_state[2*W +: W];
      d = in_state[3*W +: W];
      e = in_state[4*W +: W];
      f = in_state[5*W +: W];
      g = in_state[6*W +: W];
      h = in_state[7*W +: W];
      w = in_words[ROUND*W +: W];

      sg1    = rotr(e, S1_R0) ^ rotr(e, S1_R1) ^ rotr(e, S1_R2);
      ch     = (e & f) ^ (~e & g);
      sg0    = rotr(a, S0_R0) ^ rotr(a, S0_R1) ^ rotr(a, S0_R2);
      mj     = (a & b) ^ (a & c) ^ (b & c);
      t0     = h + sg1;
      t1     = t0 + ch;
      t2     = t1 + K_WORD;
      big_t1 = t2 + w;
      big_t2 = sg0 + mj;
      new_e  = d + big_t1;
      new_a  = big_t1 + big_t2;

      round_carries = {add_carries(big_t1, big_t2), add_carries(d, big_t1),
                       add_carries(sg0, mj), add_carries(t2, w), add_carries(t1, K_WORD),
                       add_carries(t0, ch), add_carries(h, sg1)};

      state_in   = {g, f, e, new_e, c, b, a, new_a};
      carries_in = in_carries;
      carries_in[ROUND*RW +: RW] = round_carries;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff   <= state_in;
         words_ff   <= in_words;
         carries_ff <= carries_in;
      end
   end

   assign out_ctrl    = ctrl_ff;
   assign out_state   = state_ff;
   assign out_words   = words_ff;
   assign out_carries = carries_ff;

endmodule

`default_nettype wire

FILE: src/rsce_result_buffer.sv
// pairs the two path tokens of an item and streams their fourteen carry beats
`default_nettype none

module rsce_result_buffer #(
   parameter int WORD_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rsce_pkg::token_ctrl_type              tail_ctrl,
   input  wire logic [rsce_pkg::NUM_STATE*WORD_BITS-1:0] tail_state,
   input  wire logic [rsce_pkg::NUM_ROUNDS*rsce_pkg::NUM_ADDS*WORD_BITS-1:0] tail_carries,
   output logic                                       tail_take,
   input  wire logic                                  out_ready,
   output logic                                       out_valid,
   output logic                                       out_path,
   output logic [2:0]                                 out_round,
   output logic [rsce_pkg::NUM_ADDS*WORD_BITS-1:0]    out_carries,
   output logic                                       out_equal,
   output logic                                       out_last
);

   localparam int SW      = rsce_pkg::NUM_STATE * WORD_BITS;
   localparam int RW      = rsce_pkg::NUM_ADDS * WORD_BITS;
   localparam int NR      = rsce_pkg::NUM_ROUNDS;
   localparam int NE      = rsce_pkg::RESULTS_PER_ITEM;
   localparam int COUNT_W = $clog2(NE);
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(NE - 1);
   localparam logic [COUNT_W-1:0] PATH_SPLIT = COUNT_W'(NR);

   logic [SW-1:0]          hold_state_ff;
   logic [NR*RW-1:0]       hold_carries_ff;
   logic [RW-1:0]          entry_ff [NE];
   logic [RW-1:0]          entry_in [NE];
   logic                   valid_ff, valid_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   equal_ff, equal_in;

   logic beat;
   logic last_beat;
   logic load;
   logic hold_load;
   logic second_half;

   assign beat      = valid_ff && out_ready;
   assign last_beat = beat && (count_ff == LAST_COUNT);
   // path two token completes an item once the beat buffer frees up
   assign load      = tail_ctrl.valid && tail_ctrl.path && (!valid_ff || last_beat);
   assign hold_load = tail_ctrl.valid && !tail_ctrl.path;
   assign tail_take = hold_load || load;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      equal_in = equal_ff;
      for (int i = 0; i < NE; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (load) begin
         valid_in = 1'b1;
         count_in = '0;
         equal_in = (hold_state_ff == tail_state);
         for (int r = 0; r < NR; r++) begin
            entry_in[r]      = hold_carries_ff[r*RW +: RW];
            entry_in[r + NR] = tail_carries[r*RW +: RW];
         end
      end else if (beat) begin
         if (count_ff == LAST_COUNT) begin
            valid_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
         end
         for (int i = 0; i < NE - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      equal_ff <= equal_in;
      for (int i = 0; i < NE; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (hold_load) begin
         hold_state_ff   <= tail_state;
         hold_carries_ff <= tail_carries;
      end
   end

   assign second_half = (count_ff >= PATH_SPLIT);

   assign out_valid   = valid_ff;
   assign out_path    = second_half;
   assign out_round   = second_half ? 3'(count_ff - PATH_SPLIT) : 3'(count_ff);
   assign out_carries = entry_ff[0];
   assign out_last    = (count_ff == LAST_COUNT);
   assign out_equal   = out_last && equal_ff;

endmodule

`default_nettype wire

FILE: src/reduced_sha256_carry_extractor_top.sv
// top level of the reduced sha-256 carry extractor: injector, round cell chain, beat buffer
//
// usage
//   req channel: one beat carries the seven message words of both paths
//   (rounds 57..63); each beat starts two tokens, path one then path two,
//   which walk a chain of seven round cells, one cell per round
//   rsp channel: fourteen beats per request, path one rounds 0..6 then path
//   two rounds 0..6; tlast marks the fourteenth beat, which also carries the
//   flag telling whether both final states match
//   csr port: start state of each path, write only; the user writes it only while idle (block does not enforce)
// flow
//   first rsp beat follows once the path two token has left the last cell and entered the beat buffer
//   one rsp beat per cycle while rsp tready is high; the single result port sets the request
//   rate, and a new request can be accepted while earlier beats still stream; the chain itself
//   takes a token every cycle that it advances, and a request needs two chain slots
// reset
//   synchronous, active high: chain, buffer and injector empty, both start
//   states cleared to zero
// receiver stall
//   the beat buffer holds its beat; the chain stalls as a whole once its
//   last cell holds a path two token that cannot enter the buffer, and req
//   tready drops with it
`default_nettype none

module reduced_sha256_carry_extractor_top #(
   parameter int WORD_BITS = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [55:0] first_path_words, [111:56] second_path_words
   input  wire logic [111:0] req_tdata,
   // result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [55:0] carry_bits, [56] states_equal, [63:57] zero
   output logic [63:0]       rsp_tdata,
   // [0] path_index, [3:1] round_index
   output logic [3:0]        rsp_tuser,
   // last_result
   output logic              rsp_tlast,
   // configuration write port
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [63:0]  csr_wdata
);

   localparam int NR  = rsce_pkg::NUM_ROUNDS;
   localparam int SW  = rsce_pkg::NUM_STATE * WORD_BITS;
   localparam int WW  = NR * WORD_BITS;
   localparam int RW  = rsce_pkg::NUM_ADDS * WORD_BITS;
   localparam int CW  = NR * RW;
   localparam int FW  = rsce_pkg::WORDS_FIELD_W;

   // start state registers
   logic [rsce_pkg::CSR_DATA_W-1:0] first_start_ff, first_start_in;
   logic [rsce_pkg::CSR_DATA_W-1:0] second_start_ff, second_start_in;

   // path two words waiting to enter the chain
   logic          pend_valid_ff, pend_valid_in;
   logic [WW-1:0] pend_words_ff;

   logic req_fire;
   logic advance;
   logic tail_take;

   // chain links, index 0 is the injector output
   rsce_pkg::token_ctrl_type chain_ctrl    [NR+1];
   logic [SW-1:0]            chain_state   [NR+1];
   logic [WW-1:0]            chain_words   [NR+1];
   logic [CW-1:0]            chain_carries [NR+1];

   logic          buf_valid;
   logic          buf_path;
   logic [2:0]    buf_round;
   logic [RW-1:0] buf_carries;
   logic          buf_equal;
   logic          buf_last;

   // configuration writes
   always_comb begin
      first_start_in  = first_start_ff;
      second_start_in = second_start_ff;
      if (csr_we) begin
         unique case (csr_index)
            rsce_pkg::CSR_FIRST_START:  first_start_in  = csr_wdata;
            rsce_pkg::CSR_SECOND_START: second_start_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_start_ff  <= '0;
         second_start_ff <= '0;
      end else begin
         first_start_ff  <= first_start_in;
         second_start_ff <= second_start_in;
      end
   end

   // whole chain moves when its last cell is empty or handing off
   assign advance    = !chain_ctrl[NR].valid || tail_take;
   assign req_tready = !pend_valid_ff && advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_fire) begin
         pend_valid_in = 1'b1;
      end else if (advance) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_words_ff <= req_tdata[FW +: WW];
      end
   end

   // injector: path one straight from the beat, path two from the pending words once the chain next advances
   assign chain_ctrl[0].valid = pend_valid_ff || req_fire;
   assign chain_ctrl[0].path  = pend_valid_ff;
   assign chain_state[0]      = pend_valid_ff ? second_start_ff[SW-1:0]
                                              : first_start_ff[SW-1:0];
   assign chain_words[0]      = pend_valid_ff ? pend_words_ff : req_tdata[WW-1:0];
   assign chain_carries[0]    = '0;

   for (genvar r = 0; r < NR; r++) begin : g_cell
      rsce_round_cell #(
         .WORD_BITS (WORD_BITS),
         .ROUND     (r)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_ctrl     (chain_ctrl[r]),
         .in_state    (chain_state[r]),
         .in_words    (chain_words[r]),
         .in_carries  (chain_carries[r]),
         .out_ctrl    (chain_ctrl[r+1]),
         .out_state   (chain_state[r+1]),
         .out_words   (chain_words[r+1]),
         .out_carries (chain_carries[r+1])
      );
   end

   rsce_result_buffer #(
      .WORD_BITS (WORD_BITS)
   ) u_buffer (
      .clock        (clock),
      .reset        (reset),
      .tail_ctrl    (chain_ctrl[NR]),
      .tail_state   (chain_state[NR]),
      .tail_carries (chain_carries[NR]),
      .tail_take    (tail_take),
      .out_ready    (rsp_tready),
      .out_valid    (buf_valid),
      .out_path     (buf_path),
      .out_round    (buf_round),
      .out_carries  (buf_carries),
      .out_equal    (buf_equal),
      .out_last     (buf_last)
   );

   // result beat packing
   assign rsp_tvalid = buf_valid;
   assign rsp_tdata  = {7'b0, buf_equal, rsce_pkg::CARRY_FIELD_W'(buf_carries)};
   assign rsp_tuser  = {buf_round, buf_path};
   assign rsp_tlast  = buf_last;

   // the fourteenth beat belongs to path two, round six
   a_last_is_final_round: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tuser[0] == 1'b1) && (rsp_tuser[3:1] == 3'd6))
      else $error("last beat not on path two round six");

   // equality flag only rides on the last beat
   a_equal_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tdata[56])
      else $error("states_equal set before the last beat");

   // path two injection blocks the request side until path two has entered the chain
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while path two still pending");

   // an item's beats stream without gaps once started
   a_rsp_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("result stream broke inside an item");

endmodule

`default_nettype wire
